// ===== design/crl_pkg.sv =====
package crl_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_STOPS_DEF   = 8;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 48;
  localparam int COUNT_BITS    = 4;
  localparam int PAIR_BITS     = 48;
  localparam int PAIR_COUNT    = 4;
  localparam int COLOR_BITS    = 24;
  localparam int CHAN_BITS     = 8;
  localparam int STOP_SLOTS    = 8;
  localparam int SLOT_BITS     = 3;

  localparam int                   RANGE_MAX_RST  = 1048575;
  localparam logic [COUNT_BITS-1:0] STOP_COUNT_RST = 4'd2;
  localparam logic [PAIR_BITS-1:0]  PAIR0_RST      = 48'hFFFFFF000000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RANGE_MIN  = 3'd0,
    REG_RANGE_MAX  = 3'd1,
    REG_STOP_COUNT = 3'd2,
    REG_PAIR_0     = 3'd3,
    REG_PAIR_1     = 3'd4,
    REG_PAIR_2     = 3'd5,
    REG_PAIR_3     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic clamp;
  } ctrl_t;

endpackage

// ===== design/crl_regs.sv =====
module crl_regs
  import crl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [CFG_IDX_BITS-1:0]               wr_index,
  input  logic [CFG_DATA_BITS-1:0]              wr_data,
  output logic signed [SAMPLE_BITS-1:0]         range_min,
  output logic signed [SAMPLE_BITS-1:0]         range_max,
  output logic [COUNT_BITS-1:0]                 stop_count,
  output logic [PAIR_COUNT-1:0][PAIR_BITS-1:0]  stop_pair
);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min  <= '0;
      range_max  <= SAMPLE_BITS'(RANGE_MAX_RST);
      stop_count <= STOP_COUNT_RST;
      stop_pair  <= {{((PAIR_COUNT-1)*PAIR_BITS){1'b0}}, PAIR0_RST};
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_RANGE_MIN:  range_min    <= wr_data[SAMPLE_BITS-1:0];
        REG_RANGE_MAX:  range_max    <= wr_data[SAMPLE_BITS-1:0];
        REG_STOP_COUNT: stop_count   <= wr_data[COUNT_BITS-1:0];
        REG_PAIR_0:     stop_pair[0] <= wr_data[PAIR_BITS-1:0];
        REG_PAIR_1:     stop_pair[1] <= wr_data[PAIR_BITS-1:0];
        REG_PAIR_2:     stop_pair[2] <= wr_data[PAIR_BITS-1:0];
        REG_PAIR_3:     stop_pair[3] <= wr_data[PAIR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/crl_front.sv =====
module crl_front
  import crl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_STOPS   = MAX_STOPS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int IDX_BITS    = $clog2(MAX_STOPS),
  parameter int Q_BITS      = IDX_BITS + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] range_min,
  input  logic signed [SAMPLE_BITS-1:0] range_max,
  input  logic [COUNT_BITS-1:0]         stop_count,
  output ctrl_t                         out_ctrl,
  output logic [IDX_BITS-1:0]           out_cidx,
  output logic [SAMPLE_BITS-1:0]        out_span,
  output logic [SAMPLE_BITS-1:0]        out_rem,
  output logic [Q_BITS-1:0]             out_low
);

  localparam int M_BITS = SAMPLE_BITS + IDX_BITS;

  logic [COUNT_BITS-1:0]  n_eff;
  logic [IDX_BITS-1:0]    nm1;
  logic                   low_clamp;
  logic                   high_clamp;

  ctrl_t                  a_ctrl;
  logic [IDX_BITS-1:0]    a_cidx;
  logic [IDX_BITS-1:0]    a_nm1;
  logic [SAMPLE_BITS-1:0] a_d;
  logic [SAMPLE_BITS-1:0] a_span;

  ctrl_t                  b_ctrl;
  logic [IDX_BITS-1:0]    b_cidx;
  logic [SAMPLE_BITS-1:0] b_span;
  logic [M_BITS-1:0]      b_m;

  always_comb begin
    if (stop_count == '0) begin
      n_eff = COUNT_BITS'(1);
    end else if (stop_count > COUNT_BITS'(MAX_STOPS)) begin
      n_eff = COUNT_BITS'(MAX_STOPS);
    end else begin
      n_eff = stop_count;
    end
    nm1        = IDX_BITS'(n_eff - COUNT_BITS'(1));
    low_clamp  = (n_eff == COUNT_BITS'(1)) || (sample <= range_min);
    high_clamp = sample >= range_max;
  end

  // stage A: range tests, offset and span
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl <= '0;
    end else begin
      a_ctrl.valid <= accept;
      a_ctrl.clamp <= low_clamp || high_clamp;
    end
    a_cidx <= low_clamp ? '0 : nm1;
    a_nm1  <= nm1;
    a_d    <= SAMPLE_BITS'(sample - range_min);
    a_span <= SAMPLE_BITS'(range_max - range_min);
  end

  // stage B: offset times (n-1); the fraction bits are appended as zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl <= '0;
    end else begin
      b_ctrl <= a_ctrl;
    end
    b_cidx <= a_cidx;
    b_span <= a_span;
    b_m    <= M_BITS'(a_d) * M_BITS'(a_nm1);
  end

  assign out_ctrl = b_ctrl;
  assign out_cidx = b_cidx;
  assign out_span = b_span;
  assign out_rem  = b_m[M_BITS-1:IDX_BITS];
  assign out_low  = {b_m[IDX_BITS-1:0], {FRAC_BITS{1'b0}}};

endmodule

// ===== design/crl_div_cell.sv =====
module crl_div_cell
  import crl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int IDX_BITS    = $clog2(MAX_STOPS_DEF),
  parameter int Q_BITS      = IDX_BITS + FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  in_ctrl,
  input  logic [IDX_BITS-1:0]    in_cidx,
  input  logic [SAMPLE_BITS-1:0] in_span,
  input  logic [SAMPLE_BITS-1:0] in_rem,
  input  logic [Q_BITS-1:0]      in_low,
  input  logic [Q_BITS-1:0]      in_q,
  output ctrl_t                  out_ctrl,
  output logic [IDX_BITS-1:0]    out_cidx,
  output logic [SAMPLE_BITS-1:0] out_span,
  output logic [SAMPLE_BITS-1:0] out_rem,
  output logic [Q_BITS-1:0]      out_low,
  output logic [Q_BITS-1:0]      out_q
);

  logic [SAMPLE_BITS:0] trial;
  logic [SAMPLE_BITS:0] diff;
  logic                 take;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {in_rem, in_low[Q_BITS-1]};
    diff  = trial - {1'b0, in_span};
    take  = trial >= {1'b0, in_span};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl <= in_ctrl;
    end
    out_cidx <= in_cidx;
    out_span <= in_span;
    out_rem  <= take ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
    out_low  <= {in_low[Q_BITS-2:0], 1'b0};
    out_q    <= {in_q[Q_BITS-2:0], take};
  end

endmodule

// ===== design/crl_blend.sv =====
module crl_blend
  import crl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IDX_BITS  = $clog2(MAX_STOPS_DEF),
  parameter int Q_BITS    = IDX_BITS + FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ctrl_t                                in_ctrl,
  input  logic [IDX_BITS-1:0]                  in_cidx,
  input  logic [Q_BITS-1:0]                    in_q,
  input  logic [PAIR_COUNT-1:0][PAIR_BITS-1:0] stop_pair,
  output logic                                 done,
  output logic [CHAN_BITS-1:0]                 red,
  output logic [CHAN_BITS-1:0]                 green,
  output logic [CHAN_BITS-1:0]                 blue,
  output logic                                 clamped
);

  localparam int ACC_BITS = FRAC_BITS + CHAN_BITS + 2;

  logic [STOP_SLOTS-1:0][COLOR_BITS-1:0] colors;
  logic [STOP_SLOTS-1:0][COLOR_BITS-1:0] next_colors;
  logic [SLOT_BITS-1:0]                  slot;
  logic [FRAC_BITS-1:0]                  frac;

  ctrl_t                  c_ctrl;
  logic [COLOR_BITS-1:0]  c_lo;
  logic [COLOR_BITS-1:0]  c_hi;
  logic [FRAC_BITS-1:0]   c_frac;

  logic [COLOR_BITS-1:0]  mix;

  for (genvar k = 0; k < STOP_SLOTS; k++) begin : g_slot
    assign colors[k]      = stop_pair[k / 2][(k % 2) * COLOR_BITS +: COLOR_BITS];
    assign next_colors[k] = stop_pair[((k + 1) % STOP_SLOTS) / 2]
                                     [(((k + 1) % STOP_SLOTS) % 2) * COLOR_BITS +: COLOR_BITS];
  end

  // clamped items take the end stop with a zero fraction
  always_comb begin
    if (in_ctrl.clamp) begin
      slot = SLOT_BITS'(in_cidx);
      frac = '0;
    end else begin
      slot = SLOT_BITS'(in_q[Q_BITS-1:FRAC_BITS]);
      frac = in_q[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl <= '0;
    end else begin
      c_ctrl <= in_ctrl;
    end
    c_lo   <= colors[slot];
    c_hi   <= next_colors[slot];
    c_frac <= frac;
  end

  // c + f*(d - c) + half, per channel
  always_comb begin
    logic signed [CHAN_BITS:0]   delta;
    logic signed [ACC_BITS-1:0]  acc;
    mix = '0;
    for (int ch = 0; ch < 3; ch++) begin
      delta = $signed({1'b0, c_hi[ch*CHAN_BITS +: CHAN_BITS]})
            - $signed({1'b0, c_lo[ch*CHAN_BITS +: CHAN_BITS]});
      acc   = ($signed(ACC_BITS'({c_lo[ch*CHAN_BITS +: CHAN_BITS], {FRAC_BITS{1'b0}}})))
            + ACC_BITS'(delta * $signed({1'b0, c_frac}))
            + $signed(ACC_BITS'(1) <<< (FRAC_BITS - 1));
      mix[ch*CHAN_BITS +: CHAN_BITS] = acc[FRAC_BITS +: CHAN_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_ctrl.valid;
    end
    red     <= mix[2*CHAN_BITS +: CHAN_BITS];
    green   <= mix[CHAN_BITS +: CHAN_BITS];
    blue    <= mix[0 +: CHAN_BITS];
    clamped <= c_ctrl.clamp;
  end

endmodule

// ===== design/color_ramp_lookup.sv =====
// Channel   Handshake             Payload
// input     start (busy = 0)      sample
// result    done strobe           red, green, blue, clamped
// config    cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item per cycle. The path runs through two front stages, one divider
// cell per quotient bit, then stop select and blend. busy never rises and
// cfg_ready is always high.
// Reset restores the register defaults and drops every item in flight.
// The receiver cannot stall; done is a single-cycle strobe.
module color_ramp_lookup
  import crl_pkg::*;
#(
  parameter int MAX_STOPS   = MAX_STOPS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          done,
  output logic [CHAN_BITS-1:0]          red,
  output logic [CHAN_BITS-1:0]          green,
  output logic [CHAN_BITS-1:0]          blue,
  output logic                          clamped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int IDX_BITS = $clog2(MAX_STOPS);
  localparam int Q_BITS   = IDX_BITS + FRAC_BITS;

  logic signed [SAMPLE_BITS-1:0]        range_min;
  logic signed [SAMPLE_BITS-1:0]        range_max;
  logic [COUNT_BITS-1:0]                stop_count;
  logic [PAIR_COUNT-1:0][PAIR_BITS-1:0] stop_pair;

  ctrl_t                  d_ctrl [Q_BITS+1];
  logic [IDX_BITS-1:0]    d_cidx [Q_BITS+1];
  logic [SAMPLE_BITS-1:0] d_span [Q_BITS+1];
  logic [SAMPLE_BITS-1:0] d_rem  [Q_BITS+1];
  logic [Q_BITS-1:0]      d_low  [Q_BITS+1];
  logic [Q_BITS-1:0]      d_q    [Q_BITS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  crl_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .range_min (range_min),
    .range_max (range_max),
    .stop_count(stop_count),
    .stop_pair (stop_pair)
  );

  crl_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_STOPS  (MAX_STOPS),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_BITS   (IDX_BITS),
    .Q_BITS     (Q_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (start && !busy),
    .sample    (sample),
    .range_min (range_min),
    .range_max (range_max),
    .stop_count(stop_count),
    .out_ctrl  (d_ctrl[0]),
    .out_cidx  (d_cidx[0]),
    .out_span  (d_span[0]),
    .out_rem   (d_rem[0]),
    .out_low   (d_low[0])
  );

  assign d_q[0] = '0;

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    crl_div_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .IDX_BITS   (IDX_BITS),
      .Q_BITS     (Q_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_ctrl (d_ctrl[i]),
      .in_cidx (d_cidx[i]),
      .in_span (d_span[i]),
      .in_rem  (d_rem[i]),
      .in_low  (d_low[i]),
      .in_q    (d_q[i]),
      .out_ctrl(d_ctrl[i+1]),
      .out_cidx(d_cidx[i+1]),
      .out_span(d_span[i+1]),
      .out_rem (d_rem[i+1]),
      .out_low (d_low[i+1]),
      .out_q   (d_q[i+1])
    );
  end

  crl_blend #(
    .FRAC_BITS(FRAC_BITS),
    .IDX_BITS (IDX_BITS),
    .Q_BITS   (Q_BITS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_ctrl  (d_ctrl[Q_BITS]),
    .in_cidx  (d_cidx[Q_BITS]),
    .in_q     (d_q[Q_BITS]),
    .stop_pair(stop_pair),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .clamped  (clamped)
  );

endmodule

// ===== tb/color_ramp_lookup_test.sv =====
`timescale 1ns / 100ps

module color_ramp_lookup_test;
  import crl_pkg::*;

  localparam int LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ONE = 1 << FRAC_BITS_DEF;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic                 clamped;
  } color_t;

  typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] val;
    logic                     known;
    color_t                   want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [SAMPLE_BITS_DEF-1:0] sample = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic busy, done, clamped, cfg_ready;
  logic [CHAN_BITS-1:0] red, green, blue;

  // register shadow
  logic signed [SAMPLE_BITS_DEF-1:0] cfg_min;
  logic signed [SAMPLE_BITS_DEF-1:0] cfg_max;
  logic [COUNT_BITS-1:0] cfg_count;
  logic [PAIR_BITS-1:0] cfg_pair [PAIR_COUNT];

  color_t colors_due [$];
  int errors = 0;
  int cycles = 0;

  // extremes first under the reset ramp (black to white over 0..1048575),
  // then the odd stop counts, excess register bits, reversed and empty
  // ranges, and a write to the unused index
  row_t plan [33] = '{
    '{ROW_ITEM,  '0,             48'h000000,       1'b1, {24'h000000, 1'b1}},
    '{ROW_ITEM,  '0,             48'h800000,       1'b1, {24'h000000, 1'b1}},
    '{ROW_ITEM,  '0,             48'h7FFFFF,       1'b1, {24'hFFFFFF, 1'b1}},
    '{ROW_ITEM,  '0,             48'h0FFFFF,       1'b1, {24'hFFFFFF, 1'b1}},
    '{ROW_ITEM,  '0,             48'h000001,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h080000,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h0FFFFE,       1'b0, '0},
    '{ROW_WRITE, REG_STOP_COUNT, 48'h1,            1'b0, '0},
    '{ROW_ITEM,  '0,             48'h001388,       1'b1, {24'h000000, 1'b1}},
    '{ROW_WRITE, REG_STOP_COUNT, 48'h0,            1'b0, '0},
    '{ROW_ITEM,  '0,             48'h0493E0,       1'b1, {24'h000000, 1'b1}},
    '{ROW_WRITE, REG_STOP_COUNT, 48'hFFFFFFFFFFFF, 1'b0, '0},
    '{ROW_ITEM,  '0,             48'h7FFFFF,       1'b1, {24'h000000, 1'b1}},
    '{ROW_ITEM,  '0,             48'h030D40,       1'b0, '0},
    '{ROW_WRITE, REG_PAIR_3,     48'h123456ABCDEF, 1'b0, '0},
    '{ROW_ITEM,  '0,             48'h7FFFFF,       1'b1, {24'h123456, 1'b1}},
    '{ROW_ITEM,  '0,             48'h0FFDC0,       1'b0, '0},
    '{ROW_WRITE, REG_RANGE_MIN,  48'hFFFFFF800000, 1'b0, '0},
    '{ROW_WRITE, REG_RANGE_MAX,  48'hA5A5A57FFFFF, 1'b0, '0},
    '{ROW_ITEM,  '0,             48'h800001,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h000000,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h7FFFFE,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h800000,       1'b1, {24'h000000, 1'b1}},
    '{ROW_WRITE, REG_RANGE_MIN,  48'h000064,       1'b0, '0},
    '{ROW_WRITE, REG_RANGE_MAX,  48'hFFFF9C,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h000000,       1'b1, {24'h000000, 1'b1}},
    '{ROW_ITEM,  '0,             48'h0000C8,       1'b1, {24'h123456, 1'b1}},
    '{ROW_WRITE, REG_RANGE_MIN,  48'h000032,       1'b0, '0},
    '{ROW_WRITE, REG_RANGE_MAX,  48'h000032,       1'b0, '0},
    '{ROW_ITEM,  '0,             48'h000032,       1'b1, {24'h000000, 1'b1}},
    '{ROW_ITEM,  '0,             48'h000033,       1'b1, {24'h123456, 1'b1}},
    '{ROW_WRITE, REG_UNUSED,     48'hFFFFFFFFFFFF, 1'b0, '0},
    '{ROW_ITEM,  '0,             48'h000033,       1'b1, {24'h123456, 1'b1}}
  };

  color_ramp_lookup dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .done(done),
    .red(red),
    .green(green),
    .blue(blue),
    .clamped(clamped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [COLOR_BITS-1:0] stop_rgb(int k);
    logic [PAIR_BITS-1:0] pr;
    pr = cfg_pair[k / 2];
    return (k % 2) ? pr[47:24] : pr[23:0];
  endfunction

  function automatic color_t ramp_color(logic signed [SAMPLE_BITS_DEF-1:0] s);
    int n, seg, k;
    longint v, lo, hi, q, f;
    logic [COLOR_BITS-1:0] c1, c2, mix;
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > MAX_STOPS_DEF) n = MAX_STOPS_DEF;
    v = s;
    lo = cfg_min;
    hi = cfg_max;
    if (n == 1 || v <= lo) return {stop_rgb(0), 1'b1};
    if (v >= hi) return {stop_rgb(n - 1), 1'b1};
    q = ((v - lo) * (n - 1) * ONE) / (hi - lo);
    seg = int'(q >> FRAC_BITS_DEF);
    if (seg > n - 2) seg = n - 2;
    f = q & (ONE - 1);
    c1 = stop_rgb(seg);
    c2 = stop_rgb(seg + 1);
    for (k = 0; k < 3; k++) begin
      mix[8*k +: 8] = 8'(((ONE - f) * c1[8*k +: 8] + f * c2[8*k +: 8] + ONE / 2)
                         >> FRAC_BITS_DEF);
    end
    return {mix, 1'b0};
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin : result_check
    color_t got, want;
    if (!rst && done) begin
      got = {red, green, blue, clamped};
      if (colors_due.size() == 0) begin
        note_error($sformatf("unexpected result %h %h %h %b",
                             got.red, got.green, got.blue, got.clamped));
      end else begin
        want = colors_due.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.clamped !== want.clamped) begin
          note_error($sformatf("expected rgb %h %h %h clamp %b, got %h %h %h %b",
                               want.red, want.green, want.blue, want.clamped,
                               got.red, got.green, got.blue, got.clamped));
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RANGE_MIN: cfg_min = data[23:0];
      REG_RANGE_MAX: cfg_max = data[23:0];
      REG_STOP_COUNT: cfg_count = data[COUNT_BITS-1:0];
      REG_PAIR_0, REG_PAIR_1, REG_PAIR_2, REG_PAIR_3: cfg_pair[idx - REG_PAIR_0] = data;
      default: ;
    endcase
  endtask

  // hold start low until every pending color has come back
  task automatic drain();
    start <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(logic [SAMPLE_BITS_DEF-1:0] s, int idle_pct,
                             logic known, color_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
    colors_due.push_back(known ? want : ramp_color(s));
  endtask

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
    int lo, hi;
    int unsigned r;
    lo = cfg_min;
    hi = cfg_max;
    r = $urandom_range(99);
    if (r < 70 && hi > lo) return SAMPLE_BITS_DEF'(lo + $urandom_range(0, hi - lo));
    if (r < 85) begin
      case ($urandom_range(3))
        0: return SAMPLE_BITS_DEF'(lo);
        1: return SAMPLE_BITS_DEF'(hi);
        2: return SAMPLE_BITS_DEF'(lo + 1);
        default: return SAMPLE_BITS_DEF'(hi - 1);
      endcase
    end
    return SAMPLE_BITS_DEF'($urandom);
  endfunction

  task automatic new_setting(int phase);
    int lo, hi, k;
    int unsigned pick;
    logic [63:0] raw;
    pick = (phase == 0) ? 0 : $urandom_range(3);
    case (pick)
      0: begin
        lo = -8388608;
        hi = 8388607;
      end
      1: begin
        lo = $urandom_range(0, 16777214) - 8388608;
        hi = lo + $urandom_range(1, 8388607 - lo);
      end
      2: begin
        lo = $urandom_range(0, 16000000) - 8388608;
        hi = lo + $urandom_range(1, 700);
      end
      default: begin
        // may come out reversed or empty
        lo = $urandom_range(0, 16777215) - 8388608;
        hi = $urandom_range(0, 16777215) - 8388608;
      end
    endcase
    raw = {$urandom, $urandom};
    raw[23:0] = lo[23:0];
    write_reg(REG_RANGE_MIN, raw[47:0]);
    raw = {$urandom, $urandom};
    raw[23:0] = hi[23:0];
    write_reg(REG_RANGE_MAX, raw[47:0]);
    raw = {$urandom, $urandom};
    pick = $urandom_range(9);
    if (phase == 0) raw[3:0] = 4'd8;
    else if (pick < 7) raw[3:0] = 4'($urandom_range(2, 8));
    else if (pick == 7) raw[3:0] = 4'd1;
    else if (pick == 8) raw[3:0] = 4'd0;
    else raw[3:0] = 4'($urandom_range(9, 15));
    write_reg(REG_STOP_COUNT, raw[47:0]);
    for (k = 0; k < PAIR_COUNT; k++) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(7))
        0: raw = '0;
        1: raw = '1;
        default: ;
      endcase
      write_reg(CFG_IDX_BITS'(REG_PAIR_0 + k), raw[47:0]);
    end
    if ($urandom_range(2) == 0) write_reg(REG_UNUSED, CFG_DATA_BITS'({$urandom, $urandom}));
  endtask

  initial begin : stimulus
    int i, phase, idle_pct;
    cfg_min = '0;
    cfg_max = SAMPLE_BITS_DEF'(RANGE_MAX_RST);
    cfg_count = STOP_COUNT_RST;
    cfg_pair[0] = PAIR0_RST;
    for (i = 1; i < PAIR_COUNT; i++) cfg_pair[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        send_sample(plan[r].val[23:0], 0, plan[r].known, plan[r].want);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        1: idle_pct = 61;
        3: idle_pct = 11;
        default: idle_pct = 0;
      endcase
      drain();
      new_setting(phase);
      for (i = 0; i < 110; i++) begin
        if ($urandom_range(49) == 0) drain();
        send_sample(pick_sample(), idle_pct, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
